FILE: sv/lkv_pkg.sv
`default_nettype none

package lkv_pkg;

  // Entry count: default and largest supported value.
  localparam int ENTRIES_DEF = 8;
  localparam int ENTRIES_MAX = 64;

  // Index and rank fields in the shared structs cover the largest entry count.
  localparam int IDX_W  = $clog2(ENTRIES_MAX);
  localparam int LIM_W  = IDX_W + 1;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 4;
  localparam int APB_W  = 32;
  localparam int ADDR_W = 2;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(8);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;
  localparam logic [DATA_W-1:0] PUT_VALUE  = '0;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Search token walking down the row of cells.
  typedef struct packed {
    logic              active;
    logic              op;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [IDX_W-1:0]  hit_rank;
    logic [DATA_W-1:0] hit_val;
    logic              free;
    logic [IDX_W-1:0]  free_idx;
    logic              any;
    logic [IDX_W-1:0]  old_idx;
    logic [IDX_W-1:0]  old_rank;
  } tok_t;

  // Update broadcast to every cell.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  slot;
    logic [LIM_W-1:0]  limit;
    logic              set_valid;
    logic              wr_key;
    logic              wr_val;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } upd_t;

endpackage

`default_nettype wire

FILE: sv/lkv_cell.sv
`default_nettype none

module lkv_cell #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF,
  parameter int IDX     = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  lkv_pkg::tok_t tok_in,
  input  lkv_pkg::upd_t upd,
  output lkv_pkg::tok_t tok_out
);
  import lkv_pkg::*;

  localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] MY = IDX_W'(IDX);

  logic              valid;
  logic [RW-1:0]     rank;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] value_q;
  logic [IDX_W-1:0]  rank_ext;
  tok_t              tok_next;

  assign rank_ext = IDX_W'(rank);

  // Fold this entry into the running search: first hit, first free slot, oldest.
  always_comb begin
    tok_next = tok_in;
    if (valid && key_q == tok_in.key && !tok_in.hit) begin
      tok_next.hit      = 1'b1;
      tok_next.hit_idx  = MY;
      tok_next.hit_rank = rank_ext;
      tok_next.hit_val  = value_q;
    end
    if (!valid && !tok_in.free) begin
      tok_next.free     = 1'b1;
      tok_next.free_idx = MY;
    end
    if (valid && (!tok_in.any || rank_ext > tok_in.old_rank)) begin
      tok_next.any      = 1'b1;
      tok_next.old_idx  = MY;
      tok_next.old_rank = rank_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (upd.en) begin
      if (upd.slot == MY) begin
        rank <= '0;
        if (upd.set_valid) begin
          valid <= 1'b1;
        end
      end else if (valid && LIM_W'(rank) < upd.limit) begin
        rank <= rank + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && upd.slot == MY) begin
      if (upd.wr_key) begin
        key_q <= upd.key;
      end
      if (upd.wr_val) begin
        value_q <= upd.value;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/lkv_ctrl.sv
`default_nettype none

module lkv_ctrl #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lkv_pkg::CAP_W-1:0]   capacity,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        operation,
  input  logic signed [31:0]          key,
  input  logic signed [31:0]          value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        found,
  output logic signed [31:0]          read_value,
  output lkv_pkg::tok_t               tok_launch,
  input  lkv_pkg::tok_t               tok_ret,
  output lkv_pkg::upd_t               upd
);
  import lkv_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  tok_t              res;
  logic [CNT_W-1:0]  valid_count;
  logic [CMP_W-1:0]  cap_w;
  logic [CMP_W-1:0]  eff_cap;
  logic              fill;
  logic              out_free;
  logic              finish_go;
  logic              accept;
  upd_t              dec;
  logic              dec_found;
  logic [DATA_W-1:0] dec_rv;
  logic              cnt_inc;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign finish_go = (state == S_FINISH) && out_free;

  always_comb begin
    tok_launch        = '0;
    tok_launch.active = accept;
    tok_launch.op     = operation;
    tok_launch.key    = key;
    tok_launch.value  = value;
  end

  // Capacity zero acts as one; above the entry count it saturates.
  always_comb begin
    cap_w   = CMP_W'(capacity);
    eff_cap = (cap_w == '0) ? CMP_W'(1) : cap_w;
    if (eff_cap > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end
  end

  assign fill = CMP_W'(valid_count) < eff_cap;

  always_comb begin
    dec       = '0;
    dec_found = 1'b0;
    dec_rv    = PUT_VALUE;
    cnt_inc   = 1'b0;
    dec.key   = res.key;
    dec.value = res.value;
    if (res.op == OP_GET) begin
      if (res.hit) begin
        dec.en    = 1'b1;
        dec.slot  = res.hit_idx;
        dec.limit = LIM_W'(res.hit_rank);
        dec_found = 1'b1;
        dec_rv    = res.hit_val;
      end else begin
        dec_rv = MISS_VALUE;
      end
    end else if (res.hit) begin
      dec.en     = 1'b1;
      dec.slot   = res.hit_idx;
      dec.limit  = LIM_W'(res.hit_rank);
      dec.wr_val = 1'b1;
      dec_found  = 1'b1;
    end else if (fill && res.free) begin
      dec.en        = 1'b1;
      dec.slot      = res.free_idx;
      dec.limit     = LIM_W'(ENTRIES);
      dec.set_valid = 1'b1;
      dec.wr_key    = 1'b1;
      dec.wr_val    = 1'b1;
      cnt_inc       = 1'b1;
    end else begin
      // evict least recent
      dec.en        = 1'b1;
      dec.slot      = res.old_idx;
      dec.limit     = LIM_W'(res.old_rank);
      dec.set_valid = 1'b1;
      dec.wr_key    = 1'b1;
      dec.wr_val    = 1'b1;
    end
  end

  always_comb begin
    upd    = dec;
    upd.en = dec.en && finish_go;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (tok_ret.active) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      valid_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (finish_go && cnt_inc) begin
        valid_count <= valid_count + CNT_W'(1);
      end
      if (finish_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SEARCH && tok_ret.active) begin
      res <= tok_ret;
    end
    if (finish_go) begin
      found      <= dec_found;
      read_value <= dec_rv;
    end
  end

`ifndef NO_ASSERTIONS
  a_ret_in_search: assert property (@(posedge clk) disable iff (rst)
    tok_ret.active |-> state == S_SEARCH)
    else $error("search token returned outside search");

  a_upd_in_finish: assert property (@(posedge clk) disable iff (rst)
    upd.en |-> state == S_FINISH && out_free)
    else $error("update broadcast outside finish");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(valid_count) <= CMP_W'(ENTRIES))
    else $error("valid count above entry count");

  a_accept_search: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_SEARCH)
    else $error("accepted item did not start a search");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result appeared without a finished item");
`endif

endmodule

`default_nettype wire

FILE: sv/lru_key_value_cache.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  operation, key, value
// output    out        out_valid/out_stall  found, read_value
// config    in         APB psel/penable     paddr, pwdata -> capacity (any addr)
//
// One item is handled at a time, from accept to the next accept: the
// search token walks the row of cells one cell per clock, then the finish
// state applies the update to every cell at once and loads the result register.
// The finish cycle waits while the result register is occupied and stalled.
// Reset empties the store and sets capacity to 8; no clearing pass is needed.
// in_stall is high from accept until the item's result is loaded.

module lru_key_value_cache #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // item in
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       operation,
  input  logic signed [31:0]         key,
  input  logic signed [31:0]         value,
  // result out
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       found,
  output logic signed [31:0]         read_value,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lkv_pkg::ADDR_W-1:0] paddr,
  input  logic [lkv_pkg::APB_W-1:0]  pwdata,
  output logic [lkv_pkg::APB_W-1:0]  prdata,
  output logic                       pready
);
  import lkv_pkg::*;

  logic [CAP_W-1:0] capacity;
  tok_t             links [ENTRIES+1];
  upd_t             upd;

  // Single register, written and read at every address; the address bits are ignored.
  assign pready = 1'b1;
  assign prdata = APB_W'(capacity);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr <= ADDR_W'(3)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  lkv_ctrl #(
    .ENTRIES(ENTRIES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .capacity   (capacity),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .key        (key),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .read_value (read_value),
    .tok_launch (links[0]),
    .tok_ret    (links[ENTRIES]),
    .upd        (upd)
  );

  // Row of cells: each one folds its entry into the token and passes it on.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkv_cell #(
      .ENTRIES(ENTRIES),
      .IDX    (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (links[i]),
      .upd     (upd),
      .tok_out (links[i+1])
    );
  end

endmodule

`default_nettype wire
